FILE: hdl/hysteresis_window_monitor_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the window monitor.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_WINDOW_MONITOR_TOP_MACROS_SVH
`define HYSTERESIS_WINDOW_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/hwm_pkg.sv
// ----------------------------------------------------------------------------
// hwm_pkg
// Types and constants of the hysteresis window monitor.
// ----------------------------------------------------------------------------
package hwm_pkg;

	// Field widths.
	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W    = 32;

	// Packed stream widths, rounded up to whole bytes.
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 8;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_MISORDER = 2'd1,
		STATUS_IGNORED  = 2'd2
	} status_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_FAULT_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CLEAR_LEVEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_CLEAR_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_FAULT_LEVEL = 3'd4;

	// Register values after reset.
	localparam logic [CHAN_W-1:0]          RST_CHANNEL_COUNT    = 4'd0;
	localparam logic signed [SAMPLE_W-1:0] RST_LOW_FAULT_LEVEL  = 32'sd2000;
	localparam logic signed [SAMPLE_W-1:0] RST_LOW_CLEAR_LEVEL  = 32'sd3000;
	localparam logic signed [SAMPLE_W-1:0] RST_HIGH_CLEAR_LEVEL = 32'sd9000;
	localparam logic signed [SAMPLE_W-1:0] RST_HIGH_FAULT_LEVEL = 32'sd12000;

endpackage

FILE: hdl/hysteresis_window_monitor_top.sv
// ----------------------------------------------------------------------------
// hysteresis_window_monitor_top
// Per-channel window comparator with hysteresis and a sweep fault flag.
// ----------------------------------------------------------------------------
// The block takes one sample transaction per clock cycle while the output is
// not stalled and returns exactly one result transaction for each: the sample
// is captured in an input register, the threshold compares and the latch
// update run combinationally on it, and the result waits in an output
// register. The latch read-modify-write completes as the result is registered,
// so samples of the same channel may follow each other in consecutive cycles.
// Write the configuration registers only while no transaction is in flight.
// A sample with misordered thresholds, or for a channel at or beyond the
// configured count or CHANNELS, returns a status code, touching no state.

`include "hysteresis_window_monitor_top_macros.svh"

module hysteresis_window_monitor_top
	import hwm_pkg::*;
#(
	parameter int unsigned CHANNELS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,

	// Sample stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // channel[3:0], sample[35:4], zero pad
	input  logic                  s_axis_tuser,  // sweep_start

	// Result stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // channel_fault, low_alarm,
	                                             // high_alarm, sweep_fault, zero pad
	output logic [1:0]            m_axis_tuser   // status
);

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned CNT_W = 7;

	// Configuration registers.
	logic [CHAN_W-1:0]          channel_count_q;
	logic signed [SAMPLE_W-1:0] low_fault_level_q;
	logic signed [SAMPLE_W-1:0] low_clear_level_q;
	logic signed [SAMPLE_W-1:0] high_clear_level_q;
	logic signed [SAMPLE_W-1:0] high_fault_level_q;

	// Input stage.
	logic                       valid_s1;
	logic [CHAN_W-1:0]          channel_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       sweep_start_s1;

	// Channel state.
	logic [CHANNELS-1:0]        low_latch_q;
	logic [CHANNELS-1:0]        high_latch_q;
	logic                       sweep_acc_q;

	// Result register.
	logic                       out_valid_q;
	status_t                    status_q;
	logic                       channel_fault_q;
	logic                       low_alarm_q;
	logic                       high_alarm_q;
	logic                       sweep_fault_q;

	// Step logic.
	logic                       advance;
	logic                       misorder;
	logic                       in_range;
	logic                       update;
	logic [IDX_W+CHAN_W-1:0]    chan_wide;
	logic [IDX_W-1:0]           idx;
	logic                       low_cur;
	logic                       high_cur;
	logic                       low_next;
	logic                       high_next;
	logic                       fault;
	logic                       sweep_next;
	status_t                    status_c;

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q    <= RST_CHANNEL_COUNT;
			low_fault_level_q  <= RST_LOW_FAULT_LEVEL;
			low_clear_level_q  <= RST_LOW_CLEAR_LEVEL;
			high_clear_level_q <= RST_HIGH_CLEAR_LEVEL;
			high_fault_level_q <= RST_HIGH_FAULT_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT:    channel_count_q    <= cfg_data[CHAN_W-1:0];
				REG_LOW_FAULT_LEVEL:  low_fault_level_q  <= cfg_data;
				REG_LOW_CLEAR_LEVEL:  low_clear_level_q  <= cfg_data;
				REG_HIGH_CLEAR_LEVEL: high_clear_level_q <= cfg_data;
				REG_HIGH_FAULT_LEVEL: high_fault_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			channel_s1     <= s_axis_tdata[CHAN_W-1:0];
			sample_s1      <= s_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
			sweep_start_s1 <= s_axis_tuser;
		end
	end

	// Threshold order and channel range checks.
	always_comb begin
		misorder = (low_fault_level_q > low_clear_level_q) ||
		           (low_clear_level_q > high_clear_level_q) ||
		           (high_clear_level_q > high_fault_level_q);
		in_range = (channel_s1 < channel_count_q) &&
		           ({{(CNT_W-CHAN_W){1'b0}}, channel_s1} < CNT_W'(CHANNELS));
		priority if (misorder) begin
			status_c = STATUS_MISORDER;
		end else if (!in_range) begin
			status_c = STATUS_IGNORED;
		end else begin
			status_c = STATUS_OK;
		end
		update = advance && valid_s1 && (status_c == STATUS_OK);
	end

	// Hysteresis update of the addressed channel.
	always_comb begin
		chan_wide  = {{IDX_W{1'b0}}, channel_s1};
		idx        = chan_wide[IDX_W-1:0];
		low_cur    = in_range ? low_latch_q[idx] : 1'b0;
		high_cur   = in_range ? high_latch_q[idx] : 1'b0;
		// A latched alarm holds until the sample crosses its clear level.
		low_next   = low_cur ? !(sample_s1 > low_clear_level_q)
		                     : (sample_s1 < low_fault_level_q);
		high_next  = high_cur ? !(sample_s1 < high_clear_level_q)
		                      : (sample_s1 > high_fault_level_q);
		fault      = low_next || high_next;
		sweep_next = (sweep_start_s1 ? 1'b0 : sweep_acc_q) || fault;
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_latch_q  <= '0;
			high_latch_q <= '0;
			sweep_acc_q  <= 1'b0;
		end else if (update) begin
			low_latch_q[idx]  <= low_next;
			high_latch_q[idx] <= high_next;
			sweep_acc_q       <= sweep_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= status_c;
			if (status_c == STATUS_OK) begin
				channel_fault_q <= fault;
				low_alarm_q     <= low_next;
				high_alarm_q    <= high_next;
				sweep_fault_q   <= sweep_next;
			end else begin
				channel_fault_q <= 1'b0;
				low_alarm_q     <= 1'b0;
				high_alarm_q    <= 1'b0;
				sweep_fault_q   <= 1'b0;
			end
		end
	end

	// Output packing.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {4'b0000, sweep_fault_q, high_alarm_q, low_alarm_q,
	                        channel_fault_q};

	// Assertions.
	`HWM_ASSERT_SAME(a_skip_flags_zero, clk, arst_n,
		out_valid_q && (status_q != STATUS_OK),
		m_axis_tdata == '0,
		"rejected sample reports alarm flags")
	`HWM_ASSERT_SAME(a_alarm_means_fault, clk, arst_n,
		out_valid_q && (low_alarm_q || high_alarm_q),
		channel_fault_q,
		"latched alarm without channel fault")
	`HWM_ASSERT_SAME(a_fault_in_sweep, clk, arst_n,
		out_valid_q && channel_fault_q,
		sweep_fault_q,
		"channel fault missing from sweep flag")
	`HWM_ASSERT_NEXT(a_stage_holds, clk, arst_n,
		valid_s1 && !advance,
		valid_s1,
		"input stage dropped a stalled sample")
	`HWM_ASSERT_NEXT(a_sweep_sets, clk, arst_n,
		update && fault,
		sweep_acc_q,
		"sweep accumulator not set by fault")

endmodule

FILE: verif/hysteresis_window_monitor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_window_monitor_top_test
// Self-checking testbench of the per-channel hysteresis window monitor.
// ----------------------------------------------------------------------------
// Samples go in over the slave stream and every result that comes back is
// compared field by field with a prediction computed inside the testbench.
// Directed tests cover the threshold edges, latching and clearing of both
// alarms, the sweep flag, misordered thresholds and the channel limit. Random
// phases then run under several window settings, with idle cycles on the
// input and back-pressure on the output.

module hysteresis_window_monitor_top_test;
	import hwm_pkg::*;

	localparam int CHANNELS    = 12;
	localparam int STALL_LIMIT = 2000;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

	typedef struct {
		status_t status;
		bit      channel_fault;
		bit      low_alarm;
		bit      high_alarm;
		bit      sweep_fault;
	} monitor_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // channel[3:0], sample[35:4], zero pad
	logic                  s_axis_tuser;   // sweep_start
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // channel_fault, low_alarm, high_alarm,
	                                       // sweep_fault, zero pad
	logic [1:0]            m_axis_tuser;   // status

	// Window settings and alarm state as the block should hold them.
	logic [CHAN_W-1:0]          win_count;
	logic signed [SAMPLE_W-1:0] win_low_fault;
	logic signed [SAMPLE_W-1:0] win_low_clear;
	logic signed [SAMPLE_W-1:0] win_high_clear;
	logic signed [SAMPLE_W-1:0] win_high_fault;
	bit                         low_latch [CHANNELS];
	bit                         high_latch [CHANNELS];
	bit                         sweep_acc;

	monitor_result_t pending_results[$];
	bit              steady;
	int              mismatches;
	int              samples_sent;
	int              results_checked;
	int              window_settings;
	int              stall_cycles;

	hysteresis_window_monitor_top #(
		.CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Predicts one sample's result and advances the alarm state.
	function automatic monitor_result_t window_step(input logic [CHAN_W-1:0] ch,
			input logic signed [SAMPLE_W-1:0] smp, input bit start);
		monitor_result_t r;
		int unsigned     active;
		bit              fault;
		r.status        = STATUS_OK;
		r.channel_fault = 1'b0;
		r.low_alarm     = 1'b0;
		r.high_alarm    = 1'b0;
		r.sweep_fault   = 1'b0;
		active = (win_count > CHANNELS) ? CHANNELS : win_count;
		fault  = 1'b0;
		// Misordered thresholds win over the channel limit; neither touches state.
		if (win_low_fault > win_low_clear || win_low_clear > win_high_clear ||
				win_high_clear > win_high_fault) begin
			r.status = STATUS_MISORDER;
			return r;
		end
		if (ch >= active) begin
			r.status = STATUS_IGNORED;
			return r;
		end
		if (start)
			sweep_acc = 1'b0;
		// Low side: latch below the fault level, clear above the clear level.
		if (!low_latch[ch]) begin
			if (smp < win_low_fault) begin
				low_latch[ch] = 1'b1;
				fault = 1'b1;
			end
		end else if (smp > win_low_clear) begin
			low_latch[ch] = 1'b0;
		end else begin
			fault = 1'b1;
		end
		// High side mirrors the low side.
		if (!high_latch[ch]) begin
			if (smp > win_high_fault) begin
				high_latch[ch] = 1'b1;
				fault = 1'b1;
			end
		end else if (smp < win_high_clear) begin
			high_latch[ch] = 1'b0;
		end else begin
			fault = 1'b1;
		end
		if (fault)
			sweep_acc = 1'b1;
		r.channel_fault = fault;
		r.low_alarm     = low_latch[ch];
		r.high_alarm    = high_latch[ch];
		r.sweep_fault   = sweep_acc;
		return r;
	endfunction

	// One register write; the caller lowers the write enable after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Writes all five registers and mirrors them in the predicted settings.
	task automatic program_window(input logic [CHAN_W-1:0] count,
			input logic signed [SAMPLE_W-1:0] lf, input logic signed [SAMPLE_W-1:0] lc,
			input logic signed [SAMPLE_W-1:0] hc, input logic signed [SAMPLE_W-1:0] hf);
		write_reg(REG_CHANNEL_COUNT, {{(CFG_W-CHAN_W){1'b0}}, count});
		write_reg(REG_LOW_FAULT_LEVEL, lf);
		write_reg(REG_LOW_CLEAR_LEVEL, lc);
		write_reg(REG_HIGH_CLEAR_LEVEL, hc);
		write_reg(REG_HIGH_FAULT_LEVEL, hf);
		cfg_we         <= 1'b0;
		win_count      = count;
		win_low_fault  = lf;
		win_low_clear  = lc;
		win_high_clear = hc;
		win_high_fault = hf;
		window_settings++;
	endtask

	// Sends one sample transaction, with an occasional idle gap ahead of it.
	task automatic send_sample(input logic [CHAN_W-1:0] ch,
			input logic signed [SAMPLE_W-1:0] smp, input bit start);
		int gap;
		if (!steady && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 2);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-CHAN_W-SAMPLE_W){1'b0}}, smp, ch};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(window_step(ch, smp, start));
		samples_sent++;
	endtask

	// Stops the stream and waits until every predicted result has come back.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Everything is ignored with the channel count still at zero.
	task automatic test_after_reset;
		send_sample(4'd0, 32'sd0, 1'b1);
		send_sample(4'd11, S_MIN, 1'b0);
		send_sample(4'd15, S_MAX, 1'b1);
		drain();
	endtask

	// Threshold edges, latching, hysteresis and the sweep flag.
	task automatic test_thresholds;
		program_window(4'd12, RST_LOW_FAULT_LEVEL, RST_LOW_CLEAR_LEVEL,
			RST_HIGH_CLEAR_LEVEL, RST_HIGH_FAULT_LEVEL);
		send_sample(4'd0, 32'sd2000, 1'b1);   // at the fault level: no latch
		send_sample(4'd0, 32'sd1999, 1'b1);   // just below: low alarm latches
		send_sample(4'd0, 32'sd3000, 1'b0);   // at the clear level: stays latched
		send_sample(4'd0, 32'sd3001, 1'b0);   // just above: clears, sweep stays set
		send_sample(4'd1, 32'sd12000, 1'b1);  // sweep start clears the flag
		send_sample(4'd1, 32'sd12001, 1'b0);
		send_sample(4'd1, 32'sd9000, 1'b0);
		send_sample(4'd1, 32'sd8999, 1'b0);
		send_sample(4'd11, S_MIN, 1'b0);
		send_sample(4'd11, S_MAX, 1'b0);      // low clears and high latches at once
		send_sample(4'd12, 32'sd0, 1'b1);     // beyond the count
		send_sample(4'd15, S_MIN, 1'b0);
		drain();
	endtask

	// Each kind of misordering reports an error and leaves the latches alone.
	task automatic test_misordered;
		program_window(4'd0, 32'sd5, 32'sd4, 32'sd9, 32'sd10);
		send_sample(4'd0, 32'sd0, 1'b1);      // misorder is checked before the count
		drain();
		program_window(4'd12, 32'sd1, 32'sd10, 32'sd9, 32'sd20);
		send_sample(4'd11, 32'sd0, 1'b1);
		send_sample(4'd15, S_MIN, 1'b0);
		drain();
		program_window(4'd12, 32'sd1, 32'sd2, 32'sd10, 32'sd9);
		send_sample(4'd11, S_MAX, 1'b1);
		drain();
		program_window(4'd12, RST_LOW_FAULT_LEVEL, RST_LOW_CLEAR_LEVEL,
			RST_HIGH_CLEAR_LEVEL, RST_HIGH_FAULT_LEVEL);
		send_sample(4'd11, 32'sd10000, 1'b0); // high alarm still latched
		drain();
	endtask

	// Counts above the channel number saturate; small counts cut channels off.
	task automatic test_count_limits;
		program_window(4'd15, RST_LOW_FAULT_LEVEL, RST_LOW_CLEAR_LEVEL,
			RST_HIGH_CLEAR_LEVEL, RST_HIGH_FAULT_LEVEL);
		send_sample(4'd11, 32'sd5000, 1'b0);
		send_sample(4'd12, 32'sd5000, 1'b0);
		drain();
		program_window(4'd1, RST_LOW_FAULT_LEVEL, RST_LOW_CLEAR_LEVEL,
			RST_HIGH_CLEAR_LEVEL, RST_HIGH_FAULT_LEVEL);
		send_sample(4'd0, 32'sd0, 1'b1);
		send_sample(4'd1, 32'sd0, 1'b0);
		drain();
	endtask

	// Random levels, sorted into a valid window or reversed into a bad one.
	task automatic random_window(input logic [CHAN_W-1:0] count, input bit narrow,
			input bit reversed);
		logic signed [SAMPLE_W-1:0] lv [4];
		logic signed [SAMPLE_W-1:0] t;
		for (int i = 0; i < 4; i++)
			lv[i] = narrow ? $signed($urandom_range(0, 400)) - 200 : $signed($urandom);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3 - i; j++)
				if (lv[j] > lv[j+1]) begin
					t = lv[j];
					lv[j] = lv[j+1];
					lv[j+1] = t;
				end
		if (reversed)
			program_window(count, lv[3], lv[2], lv[1], lv[0]);
		else
			program_window(count, lv[0], lv[1], lv[2], lv[3]);
	endtask

	// Random samples, mostly close to a level so the latches keep moving.
	task automatic random_samples(input int n);
		int unsigned                active;
		int unsigned                pick;
		logic [CHAN_W-1:0]          ch;
		logic signed [SAMPLE_W-1:0] smp;
		active = (win_count > CHANNELS) ? CHANNELS : win_count;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 90 && active > 0)
				ch = CHAN_W'($urandom_range(0, active - 1));
			else
				ch = CHAN_W'($urandom_range(0, 15));
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				smp = $urandom;
			end else if (pick < 9) begin
				case ($urandom_range(0, 3))
					0: smp = win_low_fault;
					1: smp = win_low_clear;
					2: smp = win_high_clear;
					default: smp = win_high_fault;
				endcase
				smp = smp + $signed($urandom_range(0, 8)) - 4;
			end else begin
				smp = $urandom_range(0, 1) ? S_MAX : S_MIN;
			end
			send_sample(ch, smp, $urandom_range(0, 15) == 0);
		end
		drain();
	endtask

	// Random phases under a range of window settings.
	task automatic test_random;
		random_window(4'd12, 1'b0, 1'b0);
		random_samples(280);
		program_window(4'd12, RST_LOW_FAULT_LEVEL, RST_LOW_CLEAR_LEVEL,
			RST_HIGH_CLEAR_LEVEL, RST_HIGH_FAULT_LEVEL);
		random_samples(280);
		random_window(CHAN_W'($urandom_range(1, 15)), 1'b1, 1'b0);
		random_samples(280);
		// Long stretch with no idling on either side.
		steady = 1'b1;
		random_window(4'd12, 1'b1, 1'b0);
		random_samples(280);
		steady = 1'b0;
		// Zero hysteresis: all four levels equal.
		program_window(4'd12, 32'sd77, 32'sd77, 32'sd77, 32'sd77);
		random_samples(220);
		// Levels at the edges of the sample range.
		program_window(4'd13, S_MIN + 1, S_MIN + 2, S_MAX - 2, S_MAX - 1);
		random_samples(220);
		program_window(4'd12, S_MIN, S_MIN, S_MAX, S_MAX);
		random_samples(120);
		random_window(4'd12, 1'b1, 1'b1);
		random_samples(60);
		random_window(CHAN_W'($urandom_range(0, 15)), 1'b0, 1'b0);
		random_samples(260);
	endtask

	// Output handshake: back-pressure and result checking.
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		monitor_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no prediction waiting");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, m_axis_tuser);
					check_field("channel_fault", want.channel_fault, m_axis_tdata[0]);
					check_field("low_alarm", want.low_alarm, m_axis_tdata[1]);
					check_field("high_alarm", want.high_alarm, m_axis_tdata[2]);
					check_field("sweep_fault", want.sweep_fault, m_axis_tdata[3]);
					results_checked++;
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
		end
	end

	// Watchdog on cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** hysteresis_window_monitor_top: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Test sequence.
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_CHANNEL_COUNT;
		cfg_data        = '0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = 1'b0;
		m_axis_tready   = 1'b0;
		steady          = 1'b0;
		mismatches      = 0;
		samples_sent    = 0;
		results_checked = 0;
		window_settings = 0;
		stall_cycles    = 0;
		win_count       = RST_CHANNEL_COUNT;
		win_low_fault   = RST_LOW_FAULT_LEVEL;
		win_low_clear   = RST_LOW_CLEAR_LEVEL;
		win_high_clear  = RST_HIGH_CLEAR_LEVEL;
		win_high_fault  = RST_HIGH_FAULT_LEVEL;
		sweep_acc       = 1'b0;
		foreach (low_latch[i]) begin
			low_latch[i]  = 1'b0;
			high_latch[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_thresholds();
		test_misordered();
		test_count_limits();
		test_random();

		$display("Run covered %0d samples and %0d checked results under %0d window settings,",
			samples_sent, results_checked, window_settings);
		$display("including threshold edges, misordered levels and channel limits.");
		if (mismatches == 0)
			$display("** hysteresis_window_monitor_top: PASSED **");
		else
			$display("** hysteresis_window_monitor_top: FAILED **");
		$finish;
	end

endmodule
